// File: design/utf8sv_pkg.sv
`default_nettype none

package utf8sv_pkg;

    // Configuration register indexes.
    localparam logic [0:0] REG_REJECT_OVERLONG        = 1'b0;
    localparam logic [0:0] REG_SUBSTITUTE_REPLACEMENT = 1'b1;
    localparam int         CFG_INDEX_W = 1;
    localparam int         CFG_DATA_W  = 1;

    localparam logic [31:0] INVALID_MARK = 32'hFFFF_FFFF;
    localparam logic [31:0] REPLACEMENT  = 32'h0000_FFFD;
    localparam logic [20:0] FLOOR_2BYTE  = 21'h00080;
    localparam logic [20:0] FLOOR_3BYTE  = 21'h00800;
    localparam logic [20:0] FLOOR_4BYTE  = 21'h10000;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [31:0] code_point;
        logic        is_invalid;
        logic [2:0]  seq_bytes;
        logic        is_end;
        logic        well_formed;
    } out_t;

    typedef struct packed {
        logic reject_overlong;
        logic substitute_replacement;
    } cfg_t;

    // Results produced by one byte: up to two, first in order in slot one.
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } dec_push_t;

endpackage

`default_nettype wire

// File: design/utf8sv_in_reg.sv
`default_nettype none

module utf8sv_in_reg
    import utf8sv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire in_t  in_data,
    output logic      item_valid,
    output in_t       item,
    input  wire logic take
);

    logic item_valid_reg;
    in_t  item_reg;
    logic load;

    // The held byte leaves only when the decoder has room for its results.
    assign in_stall   = item_valid_reg && !take;
    assign load       = !item_valid_reg || take;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: design/utf8sv_decode.sv
`default_nettype none

module utf8sv_decode
    import utf8sv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    input  wire in_t  item,
    input  wire logic take,
    input  wire cfg_t cfg,
    output dec_push_t push
);

    logic [1:0]  bexp_reg, bexp_next;
    logic [2:0]  slen_reg, slen_next;
    logic [20:0] acc_reg, acc_next;
    logic        skip_reg, skip_next;
    logic        start_reg, start_next;
    logic        wf_reg, wf_next;

    logic        consume;
    logic [7:0]  b;
    logic        is_cont;
    logic [20:0] acc_shift;
    logic [20:0] floor_val;
    logic        overlong;
    logic        run_idle;
    logic        idle_skip;
    logic        wf;
    logic        has_pre;
    logic [2:0]  pre_n;
    logic        has_main;
    logic [20:0] main_cp;
    logic        main_inv;
    logic [2:0]  main_n;
    logic        main_end;
    out_t        pre_res;
    out_t        main_res;

    function automatic out_t make_result(input logic [20:0] cp, input logic inv,
                                         input logic [2:0] n, input logic fin,
                                         input logic flag, input logic sub);
        out_t r;
        r.code_point  = inv ? (sub ? REPLACEMENT : INVALID_MARK) : {11'd0, cp};
        r.is_invalid  = inv;
        r.seq_bytes   = n;
        r.is_end      = fin;
        r.well_formed = flag;
        return r;
    endfunction

    assign consume   = item_valid && take;
    assign b         = item.data_byte;
    assign is_cont   = (b[7:6] == 2'b10);
    assign acc_shift = {acc_reg[14:0], b[5:0]};

    always_comb
    begin
        unique case (slen_reg)
            3'd2:    floor_val = FLOOR_2BYTE;
            3'd3:    floor_val = FLOOR_3BYTE;
            default: floor_val = FLOOR_4BYTE;
        endcase
    end

    assign overlong = (acc_shift < floor_val);

    always_comb
    begin
        bexp_next  = bexp_reg;
        slen_next  = slen_reg;
        acc_next   = acc_reg;
        skip_next  = skip_reg;
        start_next = start_reg;
        wf         = wf_reg;
        run_idle   = 1'b0;
        idle_skip  = skip_reg;
        has_pre    = 1'b0;
        pre_n      = slen_reg - {1'b0, bexp_reg};
        has_main   = 1'b0;
        main_cp    = '0;
        main_inv   = 1'b0;
        main_n     = 3'd0;
        main_end   = 1'b0;

        if (item.end_of_text)
        begin
            // An unfinished sequence is reported before the end marker.
            if (bexp_reg != 2'd0)
            begin
                has_pre = 1'b1;
                wf      = 1'b0;
            end
            has_main   = 1'b1;
            main_end   = 1'b1;
            bexp_next  = 2'd0;
            slen_next  = 3'd0;
            acc_next   = '0;
            skip_next  = 1'b0;
            start_next = 1'b1;
        end
        else if (bexp_reg == 2'd0)
        begin
            run_idle = 1'b1;
        end
        else if (!is_cont)
        begin
            // Sequence cut short; the byte is then decoded as a fresh lead.
            has_pre   = 1'b1;
            wf        = 1'b0;
            bexp_next = 2'd0;
            slen_next = 3'd0;
            acc_next  = '0;
            skip_next = 1'b0;
            idle_skip = 1'b0;
            run_idle  = 1'b1;
        end
        else
        begin
            acc_next  = acc_shift;
            bexp_next = bexp_reg - 2'd1;
            if (bexp_reg == 2'd1)
            begin
                if (overlong)
                begin
                    wf = 1'b0;
                end
                has_main  = 1'b1;
                main_cp   = acc_shift;
                main_inv  = overlong && cfg.reject_overlong;
                main_n    = slen_reg;
                slen_next = 3'd0;
                acc_next  = '0;
                skip_next = 1'b1;
            end
        end

        if (run_idle)
        begin
            start_next = 1'b0;
            if (is_cont)
            begin
                wf = 1'b0;
                if (!(idle_skip && !start_reg))
                begin
                    skip_next = 1'b1;
                    has_main  = 1'b1;
                    main_inv  = 1'b1;
                    main_n    = 3'd1;
                end
            end
            else if (!b[7])
            begin
                skip_next = 1'b1;
                has_main  = 1'b1;
                main_cp   = {13'd0, b};
                main_n    = 3'd1;
            end
            else if (b[7:5] == 3'b110)
            begin
                skip_next = 1'b0;
                acc_next  = {16'd0, b[4:0]};
                bexp_next = 2'd1;
                slen_next = 3'd2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                skip_next = 1'b0;
                acc_next  = {17'd0, b[3:0]};
                bexp_next = 2'd2;
                slen_next = 3'd3;
            end
            else if (b[7:3] == 5'b11110)
            begin
                skip_next = 1'b0;
                acc_next  = {18'd0, b[2:0]};
                bexp_next = 2'd3;
                slen_next = 3'd4;
            end
            else
            begin
                wf        = 1'b0;
                skip_next = 1'b1;
                has_main  = 1'b1;
                main_inv  = 1'b1;
                main_n    = 3'd1;
            end
        end

        wf_next = item.end_of_text ? 1'b1 : wf;
    end

    always_comb
    begin
        pre_res  = make_result('0, 1'b1, pre_n, 1'b0, 1'b0, cfg.substitute_replacement);
        main_res = make_result(main_cp, main_inv, main_n, main_end, wf,
                               cfg.substitute_replacement);
        push.first  = has_pre ? pre_res : main_res;
        push.second = main_res;
        if (consume)
        begin
            push.count = {1'b0, has_pre} + {1'b0, has_main};
        end
        else
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bexp_reg  <= 2'd0;
            slen_reg  <= 3'd0;
            acc_reg   <= '0;
            skip_reg  <= 1'b0;
            start_reg <= 1'b1;
            wf_reg    <= 1'b1;
        end
        else if (consume)
        begin
            bexp_reg  <= bexp_next;
            slen_reg  <= slen_next;
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
            start_reg <= start_next;
            wf_reg    <= wf_next;
        end
    end

endmodule

`default_nettype wire

// File: design/utf8sv_out_queue.sv
`default_nettype none

module utf8sv_out_queue
    import utf8sv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dec_push_t push,
    output logic           room,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_t           out_data
);

    out_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_plus1;
    logic                   pop;

    // Room is kept for the worst case of two results from one byte.
    assign room      = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + QUEUE_PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + QUEUE_PTR_W'(pop);
    assign count_next   = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

`default_nettype wire

// File: design/utf8_stream_decoder_validator.sv
// UTF-8 stream decoder and validator. One byte enters per transaction and is
// decoded into code points of up to 0x1FFFFF; malformed input gives invalid
// results and an end-of-text transaction returns the sticky well-formed
// verdict and restarts the decoder. It takes one byte per cycle while the
// four-entry result queue has room; a byte is held in the input register,
// and its results in the queue. A byte that closes a cut-short sequence and
// also yields its own result, or an end of text inside a sequence, gives two
// results; the input stalls while the queue holds more than two, so the
// output's one result per cycle, when not stalled, sets the rate.
`default_nettype none

module utf8_stream_decoder_validator
    import utf8sv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_t                        out_data,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    logic      item_valid;
    in_t       item;
    logic      room;
    dec_push_t push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REJECT_OVERLONG:        cfg_reg.reject_overlong        <= cfg_data[0];
                REG_SUBSTITUTE_REPLACEMENT: cfg_reg.substitute_replacement <= cfg_data[0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    utf8sv_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (room)
    );

    utf8sv_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (room),
        .cfg        (cfg_reg),
        .push       (push)
    );

    utf8sv_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: design/utf8sv_checker.sv
`default_nettype none

module utf8sv_checker
    import utf8sv_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire out_t out_data
);

    // The end marker carries nothing but the verdict.
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_end |->
            out_data.code_point == 32'd0 && !out_data.is_invalid &&
            out_data.seq_bytes == 3'd0)
        else $error("end marker carries a payload");

    // Every invalid report has already cleared the well-formed flag.
    a_invalid_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_invalid |->
            !out_data.well_formed && out_data.seq_bytes != 3'd0 &&
            (out_data.code_point == REPLACEMENT || out_data.code_point == INVALID_MARK))
        else $error("invalid result with wrong flag, length or code");

    // A decoded character has one to four bytes and fits in 21 bits.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_invalid && !out_data.is_end |->
            out_data.seq_bytes != 3'd0 && out_data.seq_bytes <= 3'd4 &&
            out_data.code_point[31:21] == 11'd0)
        else $error("decoded character out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_validator utf8sv_checker u_checker (.*);

`default_nettype wire
